FILE: hw/rtl/sm4_pkg.sv
// SM4 package: word types, command codes, the S-box table and the round function T.
// No dependencies; imported by sm4_block_encrypt_unit.
`default_nettype none

package sm4_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int RND_W      = $clog2(NUM_ROUNDS);
    localparam int WORD_W     = 32;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [RND_W-1:0]  t_rnd;
    typedef logic [7:0]        t_byte;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ENC  = 1'b1;

    localparam t_rnd LAST_ROUND = t_rnd'(NUM_ROUNDS - 1);

    localparam t_byte SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
        8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
        8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
        8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
        8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
        8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
        8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
        8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
        8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
        8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
        8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
        8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
        8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
        8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
        8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
        8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
        8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Apply the S-box to each byte of a word
    function automatic t_word sm4_sub(input t_word v);
        t_word r;
        r = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
        return r;
    endfunction

    // Linear diffusion: B ^ rotl2 ^ rotl10 ^ rotl18 ^ rotl24
    function automatic t_word sm4_lin(input t_word b);
        t_word r;
        r = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
              ^ {b[13:0], b[31:14]} ^ {b[7:0],  b[31:8]};
        return r;
    endfunction

    function automatic t_word sm4_t(input t_word v);
        t_word r;
        r = sm4_lin(sm4_sub(v));
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sm4_block_encrypt_unit.sv
// SM4 block cipher core: 32-entry round key store and one shared round unit.
// Depends on sm4_pkg (types, S-box table, round function).
//
//  Channel   | Handshake            | Beat contents
//  ----------+----------------------+---------------------------------------------
//  command   | start && !busy       | i_command, i_key_index, i_key_word, i_word0..3
//  result    | o_done (1 cycle)     | o_out_word0..o_out_word3
//
// A key load: the key is written at the accepting edge and busy
// stays low. An encrypt holds busy high, so no new command is taken, until its last round: the round
// unit computes one round per cycle, indexed by the round counter
// into the key store, then o_done pulses for one cycle with the result block.
// The receiver cannot stall; each result is shown exactly once.
// Synchronous reset clears the sequencer and marks every key slot as zero.
`default_nettype none

module sm4_block_encrypt_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire logic           i_command,
    input  wire sm4_pkg::t_rnd  i_key_index,
    input  wire sm4_pkg::t_word i_key_word,
    input  wire sm4_pkg::t_word i_word0,
    input  wire sm4_pkg::t_word i_word1,
    input  wire sm4_pkg::t_word i_word2,
    input  wire sm4_pkg::t_word i_word3,
    output logic                o_done,
    output sm4_pkg::t_word      o_out_word0,
    output sm4_pkg::t_word      o_out_word1,
    output sm4_pkg::t_word      o_out_word2,
    output sm4_pkg::t_word      o_out_word3
);
    import sm4_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;

    logic [0:0]            r_state, n_state;
    t_rnd                  r_round, n_round;
    logic                  r_done, n_done;
    t_word                 r_x0, r_x1, r_x2, r_x3;
    t_word                 n_x0, n_x1, n_x2, n_x3;
    t_word                 r_out0, r_out1, r_out2, r_out3;
    t_word                 n_out0, n_out1, n_out2, n_out3;
    t_word                 r_keys [NUM_ROUNDS];
    logic [NUM_ROUNDS-1:0] r_key_vld;

    logic  accept;
    logic  load_beat;
    logic  enc_beat;
    t_word round_key;
    t_word round_new;

    assign busy      = (r_state == ST_RUN);
    assign accept    = start && !busy;
    assign load_beat = accept && (i_command == CMD_LOAD);
    assign enc_beat  = accept && (i_command == CMD_ENC);

    // Slots never written read as zero
    assign round_key = r_key_vld[r_round] ? r_keys[r_round] : '0;

    // Shared round unit: X[i+4] = X[i] ^ T(X[i+1] ^ X[i+2] ^ X[i+3] ^ rk[i])
    assign round_new = r_x0 ^ sm4_t(r_x1 ^ r_x2 ^ r_x3 ^ round_key);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_done  = 1'b0;
        n_x0    = r_x0;
        n_x1    = r_x1;
        n_x2    = r_x2;
        n_x3    = r_x3;
        n_out0  = r_out0;
        n_out1  = r_out1;
        n_out2  = r_out2;
        n_out3  = r_out3;
        unique case (r_state)
            ST_IDLE: begin
                if (enc_beat) begin
                    n_state = ST_RUN;
                    n_round = '0;
                    n_x0    = i_word0;
                    n_x1    = i_word1;
                    n_x2    = i_word2;
                    n_x3    = i_word3;
                end
            end
            ST_RUN: begin
                // Shift the word window and advance the round
                n_x0    = r_x1;
                n_x1    = r_x2;
                n_x2    = r_x3;
                n_x3    = round_new;
                n_round = r_round + t_rnd'(1);
                if (r_round == LAST_ROUND) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                    n_out0  = round_new;
                    n_out1  = r_x3;
                    n_out2  = r_x2;
                    n_out3  = r_x1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_x0   <= n_x0;
        r_x1   <= n_x1;
        r_x2   <= n_x2;
        r_x3   <= n_x3;
        r_out0 <= n_out0;
        r_out1 <= n_out1;
        r_out2 <= n_out2;
        r_out3 <= n_out3;
    end

    // Key store: mark slot valid on load, drop all marks on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= '0;
        end else if (load_beat) begin
            r_key_vld[i_key_index] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_beat) begin
            r_keys[i_key_index] <= i_key_word;
        end
    end

    assign o_done      = r_done;
    assign o_out_word0 = r_out0;
    assign o_out_word1 = r_out1;
    assign o_out_word2 = r_out2;
    assign o_out_word3 = r_out3;

    // A result beat follows only the last round
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == ST_RUN && r_round == LAST_ROUND))
        else $error("result beat without a finished last round");

    // An accepted encrypt starts at round zero
    a_enc_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        enc_beat |=> (r_state == ST_RUN && r_round == '0))
        else $error("encrypt did not start at round zero");

    // The round counter rests at zero while idle
    a_idle_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_round == '0))
        else $error("round counter not at zero while idle");

    // A key load marks its slot valid
    a_load_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_beat |=> r_key_vld[$past(i_key_index)])
        else $error("loaded key slot not marked valid");

endmodule

`default_nettype wire

FILE: sim/sm4_block_encrypt_unit_checker.sv
// Checker for sm4_block_encrypt_unit: mirrors the round key store, predicts each
// ciphertext block and compares it with the strobed result. Depends on sm4_pkg types.
module sm4_block_encrypt_unit_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  logic           i_command,
    input  sm4_pkg::t_rnd  i_key_index,
    input  sm4_pkg::t_word i_key_word,
    input  sm4_pkg::t_word i_word0,
    input  sm4_pkg::t_word i_word1,
    input  sm4_pkg::t_word i_word2,
    input  sm4_pkg::t_word i_word3,
    input  logic           i_done,
    input  sm4_pkg::t_word i_res_word0,
    input  sm4_pkg::t_word i_res_word1,
    input  sm4_pkg::t_word i_res_word2,
    input  sm4_pkg::t_word i_res_word3,
    output int             o_mismatches,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sm4_pkg::*;

    // Word 0 is the most significant word of a block
    typedef t_word [0:3] t_cipher_blk;

    localparam logic [7:0] SUB_BYTES [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
        8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
        8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
        8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
        8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
        8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
        8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
        8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
        8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
        8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
        8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
        8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
        8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
        8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
        8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
        8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
        8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    t_word       key_store [NUM_ROUNDS];
    t_cipher_blk ciphertexts_due [$];
    int          mismatch_total;

    function automatic t_word rot_left(input t_word v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // Nonlinear substitution per byte, then the linear spread
    function automatic t_word mix_word(input t_word v);
        t_word b;
        b = {SUB_BYTES[v[31:24]], SUB_BYTES[v[23:16]], SUB_BYTES[v[15:8]], SUB_BYTES[v[7:0]]};
        return b ^ rot_left(b, 2) ^ rot_left(b, 10) ^ rot_left(b, 18) ^ rot_left(b, 24);
    endfunction

    // Run all rounds with the mirrored keys; output words come out reversed
    function automatic t_cipher_blk encrypt_block(input t_cipher_blk blk);
        t_word x0, x1, x2, x3, nx;
        x0 = blk[0];
        x1 = blk[1];
        x2 = blk[2];
        x3 = blk[3];
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            nx = x0 ^ mix_word(x1 ^ x2 ^ x3 ^ key_store[r]);
            x0 = x1;
            x1 = x2;
            x2 = x3;
            x3 = nx;
        end
        return {x3, x2, x1, x0};
    endfunction

    // Track accepted beats, pop expectations on each result strobe
    always @(posedge i_clk) begin
        t_cipher_blk due, seen;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ROUNDS; k++) key_store[k] = '0;
            ciphertexts_due.delete();
            mismatch_total = 0;
        end else begin
            if (i_done) begin
                seen = {i_res_word0, i_res_word1, i_res_word2, i_res_word3};
                if (ciphertexts_due.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: result beat with none outstanding: %h", $realtime, seen);
                end else begin
                    due = ciphertexts_due.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (seen[k] !== due[k]) begin
                            mismatch_total++;
                            if (mismatch_total <= 10)
                                $display("%0t: out_word%0d expected %08h, got %08h",
                                         $realtime, k, due[k], seen[k]);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_command == CMD_LOAD)
                    key_store[i_key_index] = i_key_word;
                else
                    ciphertexts_due.push_back(
                        encrypt_block({i_word0, i_word1, i_word2, i_word3}));
            end
        end
        o_pending    <= ciphertexts_due.size();
        o_mismatches <= mismatch_total;
    end

endmodule

FILE: sim/sm4_block_encrypt_unit_test.sv
// Testbench top for sm4_block_encrypt_unit: clock, reset, key loads and encrypt beats.
// Depends on sm4_pkg, the block itself and sm4_block_encrypt_unit_checker.
module sm4_block_encrypt_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sm4_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 600;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  start       = 1'b0;
    logic  i_command   = CMD_LOAD;
    t_rnd  i_key_index = '0;
    t_word i_key_word  = '0;
    t_word i_word0     = '0;
    t_word i_word1     = '0;
    t_word i_word2     = '0;
    t_word i_word3     = '0;
    logic  busy;
    logic  o_done;
    t_word o_out_word0, o_out_word1, o_out_word2, o_out_word3;

    int    mismatches;
    int    pending;
    int    stall_cycles = 0;
    bit    idle_on      = 1'b1;
    int    sent;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sm4_block_encrypt_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_key_index (i_key_index),
        .i_key_word  (i_key_word),
        .i_word0     (i_word0),
        .i_word1     (i_word1),
        .i_word2     (i_word2),
        .i_word3     (i_word3),
        .o_done      (o_done),
        .o_out_word0 (o_out_word0),
        .o_out_word1 (o_out_word1),
        .o_out_word2 (o_out_word2),
        .o_out_word3 (o_out_word3)
    );

    sm4_block_encrypt_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_command    (i_command),
        .i_key_index  (i_key_index),
        .i_key_word   (i_key_word),
        .i_word0      (i_word0),
        .i_word1      (i_word1),
        .i_word2      (i_word2),
        .i_word3      (i_word3),
        .i_done       (o_done),
        .i_res_word0  (o_out_word0),
        .i_res_word1  (o_out_word1),
        .i_res_word2  (o_out_word2),
        .i_res_word3  (o_out_word3),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Drop the run when neither a command nor a result moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("sm4_block_encrypt_unit_test NOT OK");
            $finish;
        end
    end

    // Mostly random words, with all-zero, all-one and single-bit patterns mixed in
    function automatic t_word rand_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return t_word'(1) << $urandom_range(31);
            3:       return ~(t_word'(1) << $urandom_range(31));
            default: return t_word'($urandom);
        endcase
    endfunction

    // Present one command beat, hold it until accepted, then maybe idle
    task automatic issue(input logic cmd, input t_rnd idx, input t_word kw,
                         input t_word w0, input t_word w1, input t_word w2, input t_word w3);
        start       <= 1'b1;
        i_command   <= cmd;
        i_key_index <= idx;
        i_key_word  <= kw;
        i_word0     <= w0;
        i_word1     <= w1;
        i_word2     <= w2;
        i_word3     <= w3;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (idle_on && $urandom_range(99) < 34) begin
            start <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 4)) @(posedge i_clk);
        end
    endtask

    // Block words carry noise on a key load
    task automatic load_key(input t_rnd idx, input t_word kw);
        issue(CMD_LOAD, idx, kw, rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    // Key fields carry noise on an encrypt
    task automatic encrypt(input t_word w0, input t_word w1, input t_word w2, input t_word w3);
        issue(CMD_ENC, t_rnd'($urandom), rand_word(), w0, w1, w2, w3);
    endtask

    initial begin
        bit rev;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: keys still zero from reset, then extremes at both ends of the store
        idle_on = 1'b0;
        encrypt('0, '0, '0, '0);
        encrypt('1, '1, '1, '1);
        issue(CMD_ENC, t_rnd'(NUM_ROUNDS - 1), '1, 32'h01234567, 32'h89abcdef,
              32'hfedcba98, 32'h76543210);
        issue(CMD_LOAD, '0, '1, '1, '1, '1, '1);
        load_key(LAST_ROUND, '1);
        load_key(t_rnd'(15), 32'ha5a5a5a5);
        encrypt('0, '0, '0, '0);
        encrypt('1, '1, '1, '1);
        load_key('0, '0);
        load_key(t_rnd'(7), 32'h80000000);
        load_key(t_rnd'(7), 32'h00000001);
        encrypt(32'h80000000, 32'h00000001, 32'h7fffffff, 32'hfffffffe);
        issue(CMD_ENC, '0, '0, 32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
        encrypt(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
        idle_on = 1'b1;

        // Random: full key schedules, single key updates and encrypts
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = !(sent >= 250 && sent < 400);
            case ($urandom_range(9))
                6, 7, 8: begin
                    load_key(t_rnd'($urandom_range(31)), rand_word());
                    sent++;
                end
                9: begin
                    // Reverse order writes the same slots from the last down to the first
                    rev = 1'($urandom_range(1));
                    for (int k = 0; k < NUM_ROUNDS; k++)
                        load_key(rev ? t_rnd'(NUM_ROUNDS - 1 - k) : t_rnd'(k), rand_word());
                    sent += NUM_ROUNDS;
                end
                default: begin
                    encrypt(rand_word(), rand_word(), rand_word(), rand_word());
                    sent++;
                end
            endcase
        end

        // Drain outstanding blocks, then let the round unit settle
        if (start) start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("sm4_block_encrypt_unit_test OK");
        else
            $display("sm4_block_encrypt_unit_test NOT OK");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/sm4_pkg.sv
hw/rtl/sm4_block_encrypt_unit.sv
sim/sm4_block_encrypt_unit_checker.sv
sim/sm4_block_encrypt_unit_test.sv
